/* hw/rtl/multi_queue_fifo_with_peek_assert.svh */
// Assertion macros for the multi-queue FIFO checker.
// The macros expect a signal named clk, and MQF_ASSERT also one named rst_n, in the scope where they are used.
`ifndef MULTI_QUEUE_FIFO_WITH_PEEK_ASSERT_SVH
`define MULTI_QUEUE_FIFO_WITH_PEEK_ASSERT_SVH

// Checked only while the block is out of reset.
`define MQF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define MQF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/mqf_pkg.sv */
// Shared constants, codes and helper functions of the multi-queue FIFO.
// Used by the top level and the checker; depends on nothing else.
package mqf_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int NUM_QUEUES  = 4;

  localparam int ACT_W    = 2;
  localparam int QSEL_W   = 2;
  localparam int HANDLE_W = 32;
  localparam int POS_W    = 6;
  localparam int STAT_W   = 2;
  localparam int QCNT_W   = 7;

  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int QIDX_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int ADDR_W = (NUM_QUEUES * QUEUE_DEPTH > 1) ?
                          $clog2(NUM_QUEUES * QUEUE_DEPTH) : 1;
  localparam int SUM_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam int RAM_DEPTH = NUM_QUEUES * QUEUE_DEPTH;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 48;

  typedef logic [ACT_W-1:0]  action_t;
  typedef logic [STAT_W-1:0] status_t;

  localparam action_t ACT_PUSH = 2'd0;
  localparam action_t ACT_POP  = 2'd1;
  localparam action_t ACT_PEEK = 2'd2;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;
  localparam status_t ST_RANGE = 2'd3;

  // The argument is always below twice the queue depth.
  function automatic logic [PTR_W-1:0] wrap_idx(input logic [SUM_W-1:0] v);
    logic [SUM_W-1:0] w;
    begin
      w = (v >= SUM_W'(QUEUE_DEPTH)) ? (v - SUM_W'(QUEUE_DEPTH)) : v;
      return w[PTR_W-1:0];
    end
  endfunction

endpackage

/* hw/rtl/multi_queue_fifo_with_peek.sv */
// Top level of the multi-queue FIFO with peek.
// Depends on mqf_pkg and mqf_ram.
//
// Usage: the in_ channel carries one request per handshake: an action
// (push, pop or peek), a queue select, a handle for push and a position
// for peek. The out_ channel returns exactly one result per request with
// a status, the popped or peeked handle (zero unless the status is ok) and
// the addressed queue's empty flag and entry count after the request.
// out_tvalid rises in the cycle after acceptance. While the receiver
// takes each result a new request is taken every cycle; this rate is set
// by the single write and single read port of the handle memory, with the
// head pointers and counts held in registers and updated at acceptance.
// A push written in one cycle is readable by a request in the next.
// Reset clears all pointers and counts, so every queue starts empty; the
// handle memory needs no clearing. When the receiver stalls the result is
// held in the output register and in_tready stays high only if the held
// result is taken in the same cycle.
module multi_queue_fifo_with_peek
  import mqf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [1:0] action, [3:2] queue_sel, [35:4] handle_in, [41:36] peek_pos
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [1:0] status, [33:2] handle_out, [34] queue_is_empty, [41:35] queue_count
  output logic [OUT_DATA_W-1:0] out_tdata
);

  action_t             in_action;
  logic [QSEL_W-1:0]   in_queue_sel;
  logic [HANDLE_W-1:0] in_handle;
  logic [POS_W-1:0]    in_pos;

  assign in_action    = in_tdata[1:0];
  assign in_queue_sel = in_tdata[3:2];
  assign in_handle    = in_tdata[35:4];
  assign in_pos       = in_tdata[41:36];

  logic [PTR_W-1:0] head_r [NUM_QUEUES];
  logic [CNT_W-1:0] cnt_r  [NUM_QUEUES];

  logic              out_valid_r;
  status_t           status_r;
  logic              use_rd_r;
  logic              empty_r;
  logic [QCNT_W-1:0] qcount_r;

  logic [QIDX_W+QSEL_W-1:0] qsel_ext;
  logic [QIDX_W-1:0]        qidx;
  logic                     q_present;
  logic                     accept;
  logic [PTR_W-1:0]         cur_head;
  logic [CNT_W-1:0]         cur_cnt;

  status_t           status_nxt;
  logic              use_rd_nxt;
  logic [CNT_W-1:0]  cnt_nxt;
  logic [PTR_W-1:0]  head_nxt;
  logic [PTR_W-1:0]  slot;
  logic              wr_en;
  logic              rd_en;
  logic [ADDR_W-1:0] mem_addr;
  logic [HANDLE_W-1:0] rd_data;
  logic [CNT_W+QCNT_W-1:0] cnt_ext;

  assign qsel_ext  = {{QIDX_W{1'b0}}, in_queue_sel};
  assign qidx      = qsel_ext[QIDX_W-1:0];
  assign q_present = (int'(in_queue_sel) < NUM_QUEUES);
  assign accept    = in_tvalid && in_tready;
  assign in_tready = !out_valid_r || out_tready;
  assign cur_head  = q_present ? head_r[qidx] : '0;
  assign cur_cnt   = q_present ? cnt_r[qidx] : '0;

  always_comb begin
    status_nxt = ST_OK;
    use_rd_nxt = 1'b0;
    cnt_nxt    = cur_cnt;
    head_nxt   = cur_head;
    slot       = cur_head;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    if (!q_present) begin
      cnt_nxt = '0;
      case (in_action)
        ACT_PUSH: status_nxt = ST_FULL;
        ACT_POP:  status_nxt = ST_EMPTY;
        ACT_PEEK: status_nxt = ST_RANGE;
        default:  status_nxt = ST_OK;
      endcase
    end else begin
      case (in_action)
        ACT_PUSH: begin
          if (SUM_W'(cur_cnt) >= SUM_W'(QUEUE_DEPTH)) begin
            status_nxt = ST_FULL;
          end else begin
            slot    = wrap_idx(SUM_W'(cur_head) + SUM_W'(cur_cnt));
            wr_en   = accept;
            cnt_nxt = cur_cnt + CNT_W'(1);
          end
        end
        ACT_POP: begin
          if (cur_cnt == '0) begin
            status_nxt = ST_EMPTY;
          end else begin
            slot       = cur_head;
            rd_en      = accept;
            use_rd_nxt = 1'b1;
            head_nxt   = wrap_idx(SUM_W'(cur_head) + SUM_W'(1));
            cnt_nxt    = cur_cnt - CNT_W'(1);
          end
        end
        ACT_PEEK: begin
          if (SUM_W'(in_pos) >= SUM_W'(cur_cnt)) begin
            status_nxt = ST_RANGE;
          end else begin
            slot       = wrap_idx(SUM_W'(cur_head) + SUM_W'(in_pos));
            rd_en      = accept;
            use_rd_nxt = 1'b1;
          end
        end
        default: status_nxt = ST_OK;
      endcase
    end
  end

  assign mem_addr = ADDR_W'(qidx) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(slot);
  assign cnt_ext  = {{QCNT_W{1'b0}}, cnt_nxt};

  mqf_ram #(
    .DEPTH  (RAM_DEPTH),
    .WIDTH  (HANDLE_W),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (mem_addr),
    .wdata (in_handle),
    .re    (rd_en),
    .raddr (mem_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else if (accept && q_present) begin
      head_r[qidx] <= head_nxt;
      cnt_r[qidx]  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      use_rd_r <= use_rd_nxt;
      empty_r  <= (cnt_nxt == '0);
      qcount_r <= cnt_ext[QCNT_W-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, qcount_r, empty_r,
                       (use_rd_r ? rd_data : {HANDLE_W{1'b0}}), status_r};

endmodule

/* hw/rtl/mqf_ram.sv */
// Simple dual-port RAM: one write port, one read port with registered data.
// Generic; depends on nothing else.
module mqf_ram #(
  parameter int DEPTH  = 256,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/mqf_checker.sv */
// Port-level checker for the multi-queue FIFO, bound to the top level.
// Depends on mqf_pkg and the assertion macro header.
`include "multi_queue_fifo_with_peek_assert.svh"

module mqf_checker
  import mqf_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  status_t             out_status;
  logic [HANDLE_W-1:0] out_handle;
  logic                out_empty;
  logic [QCNT_W-1:0]   out_count;
  logic                out_failed;
  logic                out_stall;

  assign out_status = out_tdata[1:0];
  assign out_handle = out_tdata[33:2];
  assign out_empty  = out_tdata[34];
  assign out_count  = out_tdata[41:35];
  assign out_failed = out_tvalid && (out_status != ST_OK);
  assign out_stall  = out_tvalid && !out_tready;

  `MQF_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_tvalid, "result valid after reset")
  `MQF_ASSERT(a_stall_hold, out_stall |=> out_tvalid && $stable(out_tdata), "held result changed")
  `MQF_ASSERT(a_fail_zero_handle, out_failed |-> out_handle == '0, "nonzero handle on failure")
  `MQF_ASSERT(a_empty_count, out_tvalid |-> out_empty == (out_count == '0), "empty flag wrong")
  `MQF_ASSERT(a_ready_when_free, !out_tvalid |-> in_tready, "request refused with free output")

endmodule

bind multi_queue_fifo_with_peek mqf_checker u_mqf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
